FILE: sv/tts_pkg.sv
// Types shared by the task timing statistics table: input beat, per-slot record,
// result beat and the control state codes. No dependencies.
package tts_pkg;

  typedef struct packed {
    logic [3:0]  task_slot;
    logic [31:0] resp_ms;
    logic [31:0] run_ms;
    logic        on_time;
    logic [31:0] lateness;
  } in_item_t;

  // One stored record per task slot.
  typedef struct packed {
    logic [31:0] activation_count;
    logic [31:0] min_response;
    logic [31:0] max_response;
    logic [63:0] response_sum;
    logic [63:0] response_sq_sum;
    logic [31:0] min_exec;
    logic [31:0] max_exec;
    logic [63:0] exec_sum;
    logic [31:0] miss_count;
    logic [63:0] late_sum;
    logic [31:0] max_late;
  } record_t;

  typedef struct packed {
    logic [31:0] activation_count;
    logic [31:0] min_response;
    logic [31:0] max_response;
    logic [63:0] response_sum;
    logic [63:0] response_sq_sum;
    logic [31:0] min_exec;
    logic [31:0] max_exec;
    logic [63:0] exec_sum;
    logic [31:0] miss_count;
    logic [63:0] late_sum;
    logic [31:0] max_late;
    logic [31:0] system_activations;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WORK = 2'b10
  } state_t;

endpackage

FILE: sv/tts_stream_if.sv
// Valid/ready stream interface carrying one payload of type T per beat.
// Used for both channels of the task timing statistics table.
interface tts_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/tts_update.sv
// Record update for one activation: counts, wrapping sums, min/max tracking
// and miss bookkeeping. Depends on tts_pkg.
module tts_update (
  input  tts_pkg::record_t  cur,
  input  tts_pkg::in_item_t item,
  input  logic [63:0]       rt_sq,
  output tts_pkg::record_t  nxt
);

  logic [31:0] n;
  logic        first;

  always_comb begin
    n     = cur.activation_count + 32'd1;
    first = (n == 32'd1);

    nxt                  = cur;
    nxt.activation_count = n;
    nxt.response_sum     = cur.response_sum + {32'd0, item.resp_ms};
    nxt.response_sq_sum  = cur.response_sq_sum + rt_sq;
    nxt.exec_sum         = cur.exec_sum + {32'd0, item.run_ms};

    // Seed min and max on a first activation, including after a count wrap.
    if (first) begin
      nxt.min_response = item.resp_ms;
      nxt.max_response = item.resp_ms;
      nxt.min_exec     = item.run_ms;
      nxt.max_exec     = item.run_ms;
    end else begin
      if (item.resp_ms < cur.min_response) nxt.min_response = item.resp_ms;
      if (item.resp_ms > cur.max_response) nxt.max_response = item.resp_ms;
      if (item.run_ms < cur.min_exec) nxt.min_exec = item.run_ms;
      if (item.run_ms > cur.max_exec) nxt.max_exec = item.run_ms;
    end

    if (!item.on_time) begin
      nxt.miss_count = cur.miss_count + 32'd1;
      nxt.late_sum   = cur.late_sum + {32'd0, item.lateness};
      if (item.lateness > cur.max_late) nxt.max_late = item.lateness;
    end
  end

endmodule

FILE: sv/task_timing_stats_table.sv
// Per-task timing statistics table. Each input beat names a task slot and one
// activation's timings; the slot's record is read from a single-port memory
// through a registered read, updated and written back, and the new record plus
// system activation count leaves as one result beat. The accept issues the
// memory read and registers the square of the response time; the work state
// then updates, writes back and loads the output register, once that register
// is free. A result waiting in the output register does not block the next
// accept; only the write-back cycle waits for it to drain. Reset clears the
// table at once through one valid bit per slot, so no clearing pass follows
// reset. Slot numbers at or above TASK_SLOTS wrap modulo TASK_SLOTS.
// Depends on tts_pkg, tts_stream_if and tts_update.
module task_timing_stats_table #(
  parameter int TASK_SLOTS = 16
) (
  input logic clk,
  input logic rst,
  tts_stream_if.sink   item,
  tts_stream_if.source result
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  tts_pkg::state_t   state;
  tts_pkg::in_item_t hold;
  tts_pkg::record_t  mem [TASK_SLOTS];
  tts_pkg::record_t  rd_data;
  tts_pkg::record_t  cur;
  tts_pkg::record_t  nxt;
  tts_pkg::out_item_t out_reg;
  logic [TASK_SLOTS-1:0] vld;
  logic        rd_vld;
  logic [SW-1:0] in_slot;
  logic [SW-1:0] slot;
  logic [63:0] rt_sq;
  logic [31:0] sys_count;
  logic [31:0] sys_count_next;
  logic        out_valid;
  logic        in_acc;
  logic        wr_en;

  // Wrap slot numbers at or above TASK_SLOTS.
  always_comb begin
    in_slot = '0;
    for (int k = 0; k < 16; k++) begin
      if (item.data.task_slot == 4'(k)) in_slot = SW'(k % TASK_SLOTS);
    end
  end

  assign item.ready   = (state == tts_pkg::S_IDLE);
  assign in_acc       = item.valid && item.ready;
  assign wr_en        = (state == tts_pkg::S_WORK) && (!out_valid || result.ready);
  assign result.valid = out_valid;
  assign result.data  = out_reg;

  // An entry never written since reset reads as zero.
  assign cur = rd_vld ? rd_data : '0;
  assign sys_count_next = sys_count + 32'd1;

  tts_update u_update (
    .cur   (cur),
    .item  (hold),
    .rt_sq (rt_sq),
    .nxt   (nxt)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[slot] <= nxt;
    if (in_acc) rd_data <= mem[in_slot];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold   <= item.data;
      slot   <= in_slot;
      rd_vld <= vld[in_slot];
      rt_sq  <= {32'd0, item.data.resp_ms} * {32'd0, item.data.resp_ms};
    end
    if (wr_en) begin
      out_reg.activation_count   <= nxt.activation_count;
      out_reg.min_response       <= nxt.min_response;
      out_reg.max_response       <= nxt.max_response;
      out_reg.response_sum       <= nxt.response_sum;
      out_reg.response_sq_sum    <= nxt.response_sq_sum;
      out_reg.min_exec           <= nxt.min_exec;
      out_reg.max_exec           <= nxt.max_exec;
      out_reg.exec_sum           <= nxt.exec_sum;
      out_reg.miss_count         <= nxt.miss_count;
      out_reg.late_sum           <= nxt.late_sum;
      out_reg.max_late           <= nxt.max_late;
      out_reg.system_activations <= sys_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tts_pkg::S_IDLE;
      vld       <= '0;
      sys_count <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        tts_pkg::S_IDLE: begin
          if (in_acc) state <= tts_pkg::S_WORK;
        end
        tts_pkg::S_WORK: begin
          // Hold the update until the output register is free.
          if (wr_en) state <= tts_pkg::S_IDLE;
        end
        default: state <= tts_pkg::S_IDLE;
      endcase
      if (wr_en) begin
        vld[slot] <= 1'b1;
        sys_count <= sys_count_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/tts_checker.sv
// Port-level checks for the task timing statistics table, and the bind that
// attaches them to the top level. Depends on tts_pkg.
module tts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tts_pkg::out_item_t out_data
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // An accepted item keeps the input closed for its update cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during update");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  // A first activation seeds min and max with the same value.
  a_seed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.activation_count == 32'd1 |->
      out_data.min_response == out_data.max_response &&
      out_data.min_exec == out_data.max_exec)
    else $error("first activation not seeded");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.min_response <= out_data.max_response &&
      out_data.min_exec <= out_data.max_exec)
    else $error("minimum above maximum");

endmodule

bind task_timing_stats_table tts_checker u_tts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);
